// ===== hw/rtl/knn1d_pkg.sv =====
package knn1d_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SAMPLE_BITS    = 32;
  localparam int NC_BITS        = 7;
  localparam int SC_BITS        = 7;
  localparam logic [NC_BITS-1:0] NC_RESET = 7'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_PUSH,
    OP_POP,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rot_m;
    logic     rot_s;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SEEK,
    S_MERGE,
    S_RESTORE,
    S_UNSTACK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          sample_label;
  } knn_in_t;

  typedef struct packed {
    logic               vote_fail;
    logic [1:0]         status;
    logic [SC_BITS-1:0] stored_count;
  } knn_out_t;

endpackage

// ===== hw/rtl/knn_1d_majority_vote_unit.sv =====
// One-dimensional nearest-neighbor classifier. The samples sit sorted in a
// row of CAPACITY cells with a second row used as a stack during queries.
// For an insert that is neither a duplicate nor into a full table, the cells
// compare the key in parallel and shift up by one place. In a query the row
// moves one entry per cycle, first the stored values below the query value
// (and equal ones labelled 0) onto the stack, then one entry per voter, then
// the rest of each side around its ring, then the stacked entries back. One
// item is worked on at a time; a finished result waits in the output register
// while the next item is taken.
module knn_1d_majority_vote_unit
  import knn1d_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  knn_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output knn_out_t           out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [NC_BITS-1:0] cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > NC_BITS) ? CW : NC_BITS;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;
  cell_ctrl_t ctrl;

  logic [NC_BITS-1:0]    nc;
  logic [VALUE_BITS-1:0] key_val;
  logic                  key_lab;
  logic                  key_mode;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         msz, msz_next;
  logic [CW-1:0]         ssz, ssz_next;
  logic [CW-1:0]         nl, nl_next;
  logic [CW-1:0]         nr, nr_next;
  logic [XW-1:0]         kk, kk_next;
  logic [XW-1:0]         taken, taken_next;
  logic [XW-1:0]         fails, fails_next;
  status_t               status_r, status_next;

  logic [VALUE_BITS-1:0] m_val [CAPACITY];
  logic                  m_lab [CAPACITY];
  logic [VALUE_BITS-1:0] s_val [CAPACITY];
  logic                  s_lab [CAPACITY];
  logic [CAPACITY-1:0]   precedes;
  logic [CAPACITY-1:0]   match;

  logic                  in_fire, out_fire, load_out;
  logic [VALUE_BITS-1:0] raw_val;
  logic [VALUE_BITS-1:0] dl, dr;
  logic                  lav, rav, take_left, seek_more, dup;
  logic [XW-1:0]         nc_x, cnt_x;
  logic [XW:0]           fails2;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  assign raw_val   = VALUE_BITS'($signed(in_data.sample_value));
  assign dl        = key_val - s_val[0];
  assign dr        = m_val[0] - key_val;
  assign lav       = (nl != ssz);
  assign rav       = (nr != msz);
  assign take_left = lav && (!rav || (dl < dr));
  assign seek_more = (msz != '0) &&
                     ((m_val[0] < key_val) || ((m_val[0] == key_val) && !m_lab[0]));
  assign dup       = |match;
  assign nc_x      = XW'(nc);
  assign cnt_x     = XW'(count);
  assign fails2    = {fails, 1'b0};
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : i - 1;
    localparam int N = (i == CAPACITY - 1) ? i : i + 1;
    knn1d_cell #(
      .IDX        (i),
      .VALUE_BITS (VALUE_BITS),
      .CW         (CW)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .key_val       (key_val),
      .key_lab       (key_lab),
      .count         (count),
      .msz           (msz),
      .ssz           (ssz),
      .m0_val        (m_val[0]),
      .m0_lab        (m_lab[0]),
      .s0_val        (s_val[0]),
      .s0_lab        (s_lab[0]),
      .prev_m_val    (m_val[P]),
      .prev_m_lab    (m_lab[P]),
      .prev_s_val    (s_val[P]),
      .prev_s_lab    (s_lab[P]),
      .prev_precedes (precedes[P]),
      .next_m_val    (m_val[N]),
      .next_m_lab    (m_lab[N]),
      .next_s_val    (s_val[N]),
      .next_s_lab    (s_lab[N]),
      .m_val         (m_val[i]),
      .m_lab         (m_lab[i]),
      .s_val         (s_val[i]),
      .s_lab         (s_lab[i]),
      .precedes      (precedes[i]),
      .match         (match[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_fire) state_next = in_data.mode ? S_SEEK : S_INS;
      S_INS:     state_next = S_DONE;
      S_SEEK:    if (!seek_more) state_next = S_MERGE;
      S_MERGE:   if (taken == kk) state_next = S_RESTORE;
      S_RESTORE: if (!lav && !rav) state_next = S_UNSTACK;
      S_UNSTACK: if (ssz == '0) state_next = S_DONE;
      S_DONE:    if (load_out) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '{op: OP_HOLD, rot_m: 1'b0, rot_s: 1'b0};
    count_next  = count;
    msz_next    = msz;
    ssz_next    = ssz;
    nl_next     = nl;
    nr_next     = nr;
    kk_next     = kk;
    taken_next  = taken;
    fails_next  = fails;
    status_next = status_r;
    unique case (state)
      S_IDLE: begin
        msz_next    = count;
        ssz_next    = '0;
        nl_next     = '0;
        nr_next     = '0;
        kk_next     = (nc_x < cnt_x) ? nc_x : cnt_x;
        taken_next  = '0;
        fails_next  = '0;
        status_next = ST_OK;
      end
      S_INS: begin
        if (dup) begin
          status_next = ST_DUP;
        end else if (count == CAP_C) begin
          status_next = ST_FULL;
        end else begin
          ctrl.op    = OP_INSERT;
          count_next = count + 1'b1;
        end
      end
      S_SEEK: begin
        if (seek_more) begin
          ctrl.op  = OP_PUSH;
          msz_next = msz - 1'b1;
          ssz_next = ssz + 1'b1;
        end
      end
      S_MERGE: begin
        if (taken != kk) begin
          ctrl.op    = OP_ROT;
          taken_next = taken + 1'b1;
          if (take_left) begin
            ctrl.rot_s = 1'b1;
            nl_next    = nl + 1'b1;
            fails_next = fails + XW'(s_lab[0]);
          end else begin
            ctrl.rot_m = 1'b1;
            nr_next    = nr + 1'b1;
            fails_next = fails + XW'(m_lab[0]);
          end
        end
      end
      S_RESTORE: begin
        // Finish each ring's turn so both sides are back in table order.
        ctrl.op    = OP_ROT;
        ctrl.rot_s = lav;
        ctrl.rot_m = rav;
        if (lav) nl_next = nl + 1'b1;
        if (rav) nr_next = nr + 1'b1;
      end
      S_UNSTACK: begin
        if (ssz != '0) begin
          ctrl.op  = OP_POP;
          ssz_next = ssz - 1'b1;
          msz_next = msz + 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      nc        <= NC_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) nc <= cfg_data;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    msz      <= msz_next;
    ssz      <= ssz_next;
    nl       <= nl_next;
    nr       <= nr_next;
    kk       <= kk_next;
    taken    <= taken_next;
    fails    <= fails_next;
    status_r <= status_next;
    if (in_fire) begin
      key_val  <= {~raw_val[VALUE_BITS-1], raw_val[VALUE_BITS-2:0]};
      key_lab  <= in_data.mode ? 1'b1 : in_data.sample_label;
      key_mode <= in_data.mode;
    end
    if (load_out) begin
      out_data.vote_fail    <= key_mode && (fails2 > {1'b0, kk});
      out_data.status       <= key_mode ? ST_OK : status_r;
      out_data.stored_count <= SC_BITS'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("stored count above capacity");

  a_restored: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && key_mode) |-> (ssz == '0 && msz == count))
    else $error("table not restored at end of query");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && count == CAP_C) |=> (count == CAP_C))
    else $error("full table changed its count");

  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (taken <= kk && (taken == kk || lav || rav)))
    else $error("neighbor walk ran past the table");
`endif

endmodule

// ===== hw/rtl/knn1d_cell.sv =====
module knn1d_cell
  import knn1d_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int CW         = 7
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] key_val,
  input  logic                  key_lab,
  input  logic [CW-1:0]         count,
  input  logic [CW-1:0]         msz,
  input  logic [CW-1:0]         ssz,
  input  logic [VALUE_BITS-1:0] m0_val,
  input  logic                  m0_lab,
  input  logic [VALUE_BITS-1:0] s0_val,
  input  logic                  s0_lab,
  input  logic [VALUE_BITS-1:0] prev_m_val,
  input  logic                  prev_m_lab,
  input  logic [VALUE_BITS-1:0] prev_s_val,
  input  logic                  prev_s_lab,
  input  logic                  prev_precedes,
  input  logic [VALUE_BITS-1:0] next_m_val,
  input  logic                  next_m_lab,
  input  logic [VALUE_BITS-1:0] next_s_val,
  input  logic                  next_s_lab,
  output logic [VALUE_BITS-1:0] m_val,
  output logic                  m_lab,
  output logic [VALUE_BITS-1:0] s_val,
  output logic                  s_lab,
  output logic                  precedes,
  output logic                  match
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [CW-1:0] IDX1  = CW'(IDX + 1);
  localparam logic          FIRST = (IDX == 0);

  logic live;

  assign live     = (IDX1 <= count);
  assign precedes = live && ((m_val < key_val) || ((m_val == key_val) && !m_lab && key_lab));
  assign match    = live && (m_val == key_val) && (m_lab == key_lab);

  // Main row holds the table (and the right side during a query); the stack
  // row holds the left side with the nearest entry in cell 0.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_INSERT: begin
        if (!precedes) begin
          if (FIRST || prev_precedes) begin
            m_val <= key_val;
            m_lab <= key_lab;
          end else if (IDX_C <= count) begin
            m_val <= prev_m_val;
            m_lab <= prev_m_lab;
          end
        end
      end
      OP_PUSH: begin
        m_val <= next_m_val;
        m_lab <= next_m_lab;
        s_val <= FIRST ? m0_val : prev_s_val;
        s_lab <= FIRST ? m0_lab : prev_s_lab;
      end
      OP_POP: begin
        m_val <= FIRST ? s0_val : prev_m_val;
        m_lab <= FIRST ? s0_lab : prev_m_lab;
        s_val <= next_s_val;
        s_lab <= next_s_lab;
      end
      OP_ROT: begin
        if (ctrl.rot_m) begin
          m_val <= (IDX1 == msz) ? m0_val : next_m_val;
          m_lab <= (IDX1 == msz) ? m0_lab : next_m_lab;
        end
        if (ctrl.rot_s) begin
          s_val <= (IDX1 == ssz) ? s0_val : next_s_val;
          s_lab <= (IDX1 == ssz) ? s0_lab : next_s_lab;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
